// ===== rtl/core/vda_pkg.sv =====
package vda_pkg;

  localparam int unsigned DoseW = 48;
  localparam int unsigned SqW   = 64;
  localparam int unsigned CntW  = 32;
  localparam int unsigned ErrW  = 16;
  localparam int unsigned QW    = 40;
  localparam int unsigned MacW  = 128;
  localparam int unsigned MultW = 48;

  // 10000^2: percent in 0.01 units, squared under the root
  localparam logic [MultW-1:0] ErrScale = 48'd100000000;

  typedef struct packed {
    logic [DoseW-1:0] dose;
    logic [SqW-1:0]   sq;
    logic [CntW-1:0]  hits;
    logic [ErrW-1:0]  err;
  } vda_entry_t;

  typedef struct packed {
    logic            start;
    logic [MacW-1:0] a1;
    logic [MultW-1:0] b1;
    logic [MacW-1:0] a2;
    logic [MultW-1:0] b2;
  } vda_mul_req_t;

endpackage

// ===== rtl/core/voxel_dose_accumulator.sv =====
// A rejected hit goes from acceptance straight to the output stage; a scored hit is read,
// squared on the shift-add lanes and summed, then, with more than one hit and a nonzero
// sum, takes the error multiplies on the shared shift-add lanes and the bit-serial
// divide/root sequence (cut short when the error saturates). One hit at a time: no new hit
// is taken until the result is loaded into the output register. Reset clears control state
// and then sweeps all X*Y*Z entries of the voxel store (262144 by default) to zero, one entry per cycle.
module voxel_dose_accumulator #(
  parameter int unsigned X_VOXELS = 64,
  parameter int unsigned Y_VOXELS = 64,
  parameter int unsigned Z_VOXELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // hit channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  x_index_i,
  input  logic [5:0]  y_index_i,
  input  logic [5:0]  z_index_i,
  input  logic [23:0] energy_deposit_i,
  input  logic        in_scoring_volume_i,
  input  logic        readout_present_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [47:0] voxel_dose_total_o,
  output logic [31:0] voxel_hits_o,
  output logic [15:0] relative_error_o,
  output logic [31:0] scored_hits_total_o
);

  localparam int unsigned VoxelCount = X_VOXELS * Y_VOXELS * Z_VOXELS;
  localparam int unsigned AddrW      = (VoxelCount > 1) ? $clog2(VoxelCount) : 1;

  // sequencer codes
  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SRead = 4'd1;
  localparam logic [3:0] SSq   = 4'd2;
  localparam logic [3:0] SChk  = 4'd3;
  localparam logic [3:0] SVar  = 4'd4;
  localparam logic [3:0] SScl  = 4'd5;
  localparam logic [3:0] SMul2 = 4'd6;
  localparam logic [3:0] SRt   = 4'd7;
  localparam logic [3:0] SRtW  = 4'd8;
  localparam logic [3:0] SWr   = 4'd9;
  localparam logic [3:0] SDone = 4'd10;

  logic [3:0]                 state_q, state_d;
  logic [31:0]                inv_mass_q;
  logic [31:0]                total_q, total_d;
  logic [AddrW-1:0]           addr_q, addr_d;
  logic [vda_pkg::QW-1:0]     q_q, q_d;
  logic                       acc_q, acc_d;
  logic [vda_pkg::DoseW-1:0]  s_q, s_d;
  logic [vda_pkg::SqW-1:0]    s2_q, s2_d;
  logic [vda_pkg::CntW-1:0]   n_q, n_d;
  logic [vda_pkg::ErrW-1:0]   e_q, e_d;
  logic [vda_pkg::MacW-1:0]   t1_q, t1_d, t2_q, t2_d;

  logic                       in_accept;
  logic                       hit_ok;
  logic [31:0]                lin_addr;
  logic [55:0]                dep_prod;
  logic                       store_busy;
  vda_pkg::vda_entry_t        rd_entry, wr_entry;
  logic                       mem_we;
  vda_pkg::vda_mul_req_t      mreq;
  logic                       mul_done;
  logic [vda_pkg::MacW-1:0]   p1, p2;
  logic                       rt_start, rt_done;
  logic [vda_pkg::ErrW-1:0]   rt_err;
  logic [vda_pkg::SqW-1:0]    sq_sat;
  logic [vda_pkg::DoseW:0]    s_sum;
  logic [vda_pkg::SqW:0]      s2_sum;
  logic                       out_load;

  // --------------------------------------------------------------------------
  // Configuration: one register, inverse voxel mass (Q16.16)
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? inv_mass_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q <= 32'h0001_0000;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      inv_mass_q <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // Input qualification: a hit is scored only with readout, inside the scoring
  // volume, with a nonzero deposit and with indices inside the grid.
  // --------------------------------------------------------------------------
  assign in_stall_o = store_busy || (state_q != SIdle);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign hit_ok = readout_present_i && in_scoring_volume_i && (energy_deposit_i != 24'd0)
                  && (32'(x_index_i) < 32'(X_VOXELS))
                  && (32'(y_index_i) < 32'(Y_VOXELS))
                  && (32'(z_index_i) < 32'(Z_VOXELS));

  assign lin_addr = (32'(x_index_i) * 32'(Y_VOXELS) + 32'(y_index_i)) * 32'(Z_VOXELS)
                    + 32'(z_index_i);

  // dose quantum: deposit times inverse mass, drop the 16 fraction bits
  assign dep_prod = 56'(energy_deposit_i) * 56'(inv_mass_q);

  // --------------------------------------------------------------------------
  // Voxel store. Only one hit is in flight and its write-back lands before the
  // next read, so no forwarding is needed.
  // --------------------------------------------------------------------------
  assign mem_we = (state_q == SWr);
  assign wr_entry = '{dose: s_q, sq: s2_q, hits: n_q, err: e_q};

  vda_store #(
    .VoxelCount (VoxelCount),
    .AddrW      (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (lin_addr[AddrW-1:0]),
    .rd_data_o (rd_entry),
    .wr_en_i   (mem_we),
    .wr_addr_i (addr_q),
    .wr_data_i (wr_entry),
    .busy_o    (store_busy)
  );

  vda_mul2 u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mul_done),
    .p1_o   (p1),
    .p2_o   (p2)
  );

  assign rt_start = (state_q == SRt);

  vda_rootdiv u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rt_start),
    .num_i   (t1_q),
    .den_i   (t2_q),
    .done_o  (rt_done),
    .err_o   (rt_err)
  );

  // saturating sums of the update
  assign sq_sat = (p1[vda_pkg::MacW-1:vda_pkg::SqW] != '0) ? '1 : p1[vda_pkg::SqW-1:0];
  assign s_sum  = {1'b0, s_q} + (vda_pkg::DoseW + 1)'(q_q);
  assign s2_sum = {1'b0, s2_q} + {1'b0, sq_sat};

  // --------------------------------------------------------------------------
  // Sequencer: read, square the quantum, update sums, then, with more than one hit and a
  // nonzero sum, the error chain n*S2 and S*S, scale by 1e8 and S*S*(n-1), divide, take the root.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    total_d = total_q;
    addr_d  = addr_q;
    q_d     = q_q;
    acc_d   = acc_q;
    s_d     = s_q;
    s2_d    = s2_q;
    n_d     = n_q;
    e_d     = e_q;
    t1_d    = t1_q;
    t2_d    = t2_q;
    mreq    = '0;
    unique case (state_q)
      SIdle: begin
        if (in_accept) begin
          addr_d  = lin_addr[AddrW-1:0];
          q_d     = dep_prod[55:16];
          acc_d   = hit_ok;
          state_d = hit_ok ? SRead : SDone;
        end
      end
      SRead: begin
        s_d        = rd_entry.dose;
        s2_d       = rd_entry.sq;
        n_d        = rd_entry.hits;
        e_d        = rd_entry.err;
        mreq.start = 1'b1;
        mreq.a1    = vda_pkg::MacW'(q_q);
        mreq.b1    = vda_pkg::MultW'(q_q);
        state_d    = SSq;
      end
      SSq: begin
        if (mul_done) begin
          s_d  = s_sum[vda_pkg::DoseW] ? '1 : s_sum[vda_pkg::DoseW-1:0];
          s2_d = s2_sum[vda_pkg::SqW] ? '1 : s2_sum[vda_pkg::SqW-1:0];
          if (n_q != '1) begin
            n_d = n_q + 32'd1;
          end
          if (total_q != '1) begin
            total_d = total_q + 32'd1;
          end
          state_d = SChk;
        end
      end
      SChk: begin
        if (n_q > 32'd1 && s_q != '0) begin
          mreq.start = 1'b1;
          mreq.a1    = vda_pkg::MacW'(s2_q);
          mreq.b1    = vda_pkg::MultW'(n_q);
          mreq.a2    = vda_pkg::MacW'(s_q);
          mreq.b2    = s_q;
          state_d    = SVar;
        end else begin
          if (n_q > 32'd1) begin
            e_d = '0;
          end
          state_d = SWr;
        end
      end
      SVar: begin
        if (mul_done) begin
          if (p1 > p2) begin
            t1_d    = p1 - p2;
            t2_d    = p2;
            state_d = SScl;
          end else begin
            e_d     = '0;
            state_d = SWr;
          end
        end
      end
      SScl: begin
        mreq.start = 1'b1;
        mreq.a1    = t1_q;
        mreq.b1    = vda_pkg::ErrScale;
        mreq.a2    = t2_q;
        mreq.b2    = vda_pkg::MultW'(n_q - 32'd1);
        state_d    = SMul2;
      end
      SMul2: begin
        if (mul_done) begin
          t1_d    = p1;
          t2_d    = p2;
          state_d = SRt;
        end
      end
      SRt: begin
        state_d = SRtW;
      end
      SRtW: begin
        if (rt_done) begin
          e_d     = rt_err;
          state_d = SWr;
        end
      end
      SWr: begin
        state_d = SDone;
      end
      SDone: begin
        if (out_load) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    q_q    <= q_d;
    acc_q  <= acc_d;
    s_q    <= s_d;
    s2_q   <= s2_d;
    n_q    <= n_d;
    e_q    <= e_d;
    t1_q   <= t1_d;
    t2_q   <= t2_d;
  end

  // --------------------------------------------------------------------------
  // Output register: load the finished beat once the previous one is taken.
  // --------------------------------------------------------------------------
  assign out_load = (state_q == SDone) && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      accepted_o          <= acc_q;
      voxel_dose_total_o  <= acc_q ? s_q : '0;
      voxel_hits_o        <= acc_q ? n_q : '0;
      relative_error_o    <= acc_q ? e_q : '0;
      scored_hits_total_o <= total_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_clear_blocks_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_busy |-> in_stall_o)
    else $error("hit accepted during store clear");

  a_write_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> acc_q && (n_q != '0))
    else $error("store write without a scored hit");

  a_scored_has_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> voxel_hits_o != '0 && scored_hits_total_o != '0)
    else $error("scored beat with zero count");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> voxel_dose_total_o == '0 && voxel_hits_o == '0
      && relative_error_o == '0)
    else $error("rejected beat carries voxel data");

  a_total_moves_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != $past(total_q)) |-> $past(state_q) == SSq)
    else $error("total changed outside the update step");

endmodule

// ===== rtl/core/vda_store.sv =====
module vda_store #(
  parameter int unsigned VoxelCount = 262144,
  parameter int unsigned AddrW      = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output vda_pkg::vda_entry_t  rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  vda_pkg::vda_entry_t  wr_data_i,
  output logic                 busy_o
);

  localparam int unsigned EntryW = $bits(vda_pkg::vda_entry_t);

  logic [EntryW-1:0] mem [VoxelCount];
  logic [EntryW-1:0] rd_data_q;
  logic              clr_busy_q, clr_busy_d;
  logic [AddrW-1:0]  clr_addr_q, clr_addr_d;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [EntryW-1:0] wdata;

  // sweep every entry to zero after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(VoxelCount - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we    = clr_busy_q | wr_en_i;
  assign waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = vda_pkg::vda_entry_t'(rd_data_q);
  assign busy_o    = clr_busy_q;

endmodule

// ===== rtl/core/vda_mul2.sv =====
module vda_mul2 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vda_pkg::vda_mul_req_t       req_i,
  output logic                        done_o,
  output logic [vda_pkg::MacW-1:0]    p1_o,
  output logic [vda_pkg::MacW-1:0]    p2_o
);

  // two shift-add lanes, one multiplier bit per cycle each
  logic                       run_q;
  logic [vda_pkg::MacW-1:0]   a1_q, a2_q, acc1_q, acc2_q;
  logic [vda_pkg::MultW-1:0]  b1_q, b2_q;

  assign done_o = run_q && (b1_q == '0) && (b2_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (req_i.start) begin
      run_q <= 1'b1;
    end else if (done_o) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a1_q   <= req_i.a1;
      b1_q   <= req_i.b1;
      a2_q   <= req_i.a2;
      b2_q   <= req_i.b2;
      acc1_q <= '0;
      acc2_q <= '0;
    end else if (run_q) begin
      if (b1_q[0]) begin
        acc1_q <= acc1_q + a1_q;
      end
      if (b2_q[0]) begin
        acc2_q <= acc2_q + a2_q;
      end
      a1_q <= a1_q << 1;
      a2_q <= a2_q << 1;
      b1_q <= b1_q >> 1;
      b2_q <= b2_q >> 1;
    end
  end

  assign p1_o = acc1_q;
  assign p2_o = acc2_q;

endmodule

// ===== rtl/core/vda_rootdiv.sv =====
module vda_rootdiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vda_pkg::MacW-1:0]    num_i,
  input  logic [vda_pkg::MacW-1:0]    den_i,
  output logic                        done_o,
  output logic [vda_pkg::ErrW-1:0]    err_o
);

  localparam logic [1:0] RdIdle = 2'd0;
  localparam logic [1:0] RdDiv  = 2'd1;
  localparam logic [1:0] RdSqrt = 2'd2;
  localparam logic [1:0] RdDone = 2'd3;
  localparam int unsigned DvsW  = vda_pkg::MacW + 32;

  logic [1:0]                state_q, state_d;
  logic [4:0]                cnt_q, cnt_d;
  logic [vda_pkg::MacW-1:0]  rem_q, rem_d;
  logic [DvsW-1:0]           dvs_q, dvs_d;
  logic [31:0]               quo_q, quo_d;
  logic [31:0]               res_q, res_d;
  logic [31:0]               bit_q, bit_d;
  logic [vda_pkg::ErrW-1:0]  err_q, err_d;
  logic [32:0]               trial;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    res_d   = res_q;
    bit_d   = bit_q;
    err_d   = err_q;
    unique case (state_q)
      RdIdle: begin
        if (start_i) begin
          if ({32'd0, num_i} >= {den_i, 32'd0}) begin
            err_d   = '1;
            state_d = RdDone;
          end else begin
            rem_d   = num_i;
            dvs_d   = {1'b0, den_i, 31'd0};
            quo_d   = '0;
            cnt_d   = 5'd31;
            state_d = RdDiv;
          end
        end
      end
      RdDiv: begin
        if ({32'd0, rem_q} >= dvs_q) begin
          rem_d        = rem_q - dvs_q[vda_pkg::MacW-1:0];
          quo_d[cnt_q] = 1'b1;
        end
        dvs_d = dvs_q >> 1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          res_d   = '0;
          bit_d   = 32'h4000_0000;
          cnt_d   = 5'd15;
          state_d = RdSqrt;
        end
      end
      RdSqrt: begin
        if ({1'b0, quo_q} >= trial) begin
          quo_d = quo_q - trial[31:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = RdDone;
        end
      end
      RdDone: begin
        state_d = RdIdle;
      end
      default: state_d = RdIdle;
    endcase
    if (state_q == RdSqrt && cnt_q == 5'd0) begin
      err_d = res_d[vda_pkg::ErrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RdIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    res_q <= res_d;
    bit_q <= bit_d;
    err_q <= err_d;
  end

  assign done_o = (state_q == RdDone);
  assign err_o  = err_q;

endmodule
